/* sv/qaar_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qaar_pkg
// shared widths, cordic constants and rounding helper for the axis-angle rotator
// ----------------------------------------------------------------------------
package qaar_pkg;

    localparam int TRIG_STAGES      = 16;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int NSTG = (TRIG_STAGES > CORDIC_TABLE_LEN) ? CORDIC_TABLE_LEN : TRIG_STAGES;

    localparam int CW = 34;     // cordic x/y and quaternion terms, q.30
    localparam int ZW = 33;     // cordic residual angle
    localparam int EW = 36;     // matrix entries before rounding
    localparam int TW = 40;     // one rounded row term, q.16
    localparam int SW = 42;     // row sum before saturation

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } t_vec;

    typedef struct packed {
        t_vec               v;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
    } t_item;

    function automatic logic signed [ZW-1:0] atan_bam(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:       r = ZW'(64'sd536870912);
            1:       r = ZW'(64'sd316933406);
            2:       r = ZW'(64'sd167458907);
            3:       r = ZW'(64'sd85004756);
            4:       r = ZW'(64'sd42667331);
            5:       r = ZW'(64'sd21354465);
            6:       r = ZW'(64'sd10680862);
            7:       r = ZW'(64'sd5340245);
            8:       r = ZW'(64'sd2670163);
            9:       r = ZW'(64'sd1335087);
            10:      r = ZW'(64'sd667544);
            11:      r = ZW'(64'sd333772);
            12:      r = ZW'(64'sd166886);
            13:      r = ZW'(64'sd83443);
            14:      r = ZW'(64'sd41722);
            15:      r = ZW'(64'sd20861);
            16:      r = ZW'(64'sd10430);
            17:      r = ZW'(64'sd5215);
            18:      r = ZW'(64'sd2608);
            19:      r = ZW'(64'sd1304);
            20:      r = ZW'(64'sd652);
            21:      r = ZW'(64'sd326);
            22:      r = ZW'(64'sd163);
            23:      r = ZW'(64'sd81);
            default: r = '0;
        endcase
        return r;
    endfunction

    // add half an lsb then floor shift
    function automatic logic signed [71:0] rnd(input logic signed [71:0] x, input int s);
        logic signed [71:0] h;
        h = 72'sd1 <<< (s - 1);
        return (x + h) >>> s;
    endfunction

    function automatic logic signed [15:0] clamp_axis(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v > 16'sd16384) begin
            r = 16'sd16384;
        end else if (v < -16'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/quaternion_axis_angle_rotate_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_axis_angle_rotate_top
// rotates a q16.16 vector about a q1.14 axis by a binary angle
// ----------------------------------------------------------------------------
// input channel: i_valid with o_stall; a request carries the vector, the
// angle (65536 = full turn) and the axis, taken when i_valid && !o_stall.
// output channel: o_valid with i_stall; a valid rotated vector is held while
// i_stall is high.
// one request per cycle is accepted unless the output is stalled. the
// pipeline is 1 input register, NSTG cordic stages, then the
// quaternion, products, matrix, row terms and sum/saturate stages;
// qaar_pkg::NSTG sets the cordic stage count.
// the whole pipeline advances together; it halts only when the output
// register holds a result and the receiver stalls, so bubbles never block.
// reset clears every valid bit; payload registers are not reset.
// the axis is clamped to +/-1.0 but not normalised; outputs saturate.
// ----------------------------------------------------------------------------
module quaternion_axis_angle_rotate_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic        [15:0] i_angle,
    input  wire logic signed [15:0] i_axis_x,
    input  wire logic signed [15:0] i_axis_y,
    input  wire logic signed [15:0] i_axis_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_rot_x,
    output logic signed [31:0]      o_rot_y,
    output logic signed [31:0]      o_rot_z
);

    localparam int N  = qaar_pkg::NSTG;
    localparam int CW = qaar_pkg::CW;
    localparam int EW = qaar_pkg::EW;
    localparam int TW = qaar_pkg::TW;
    localparam int SW = qaar_pkg::SW;

    logic w_en;
    logic r_vld [0:N];
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_out_vld;

    qaar_pkg::t_item r_it [0:N];

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_vld;

    logic signed [CW-1:0] w_cos, w_sin;

    qaar_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_angle),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
            r_vld_c   <= 1'b0;
            r_vld_d   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < N; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_vld_a   <= r_vld[N];
            r_vld_b   <= r_vld_a;
            r_vld_c   <= r_vld_b;
            r_vld_d   <= r_vld_c;
            r_out_vld <= r_vld_d;
        end
    end

    // vector and axis travel alongside the cordic
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_it[0].v.vx <= i_vec_x;
            r_it[0].v.vy <= i_vec_y;
            r_it[0].v.vz <= i_vec_z;
            r_it[0].ux   <= qaar_pkg::clamp_axis(i_axis_x);
            r_it[0].uy   <= qaar_pkg::clamp_axis(i_axis_y);
            r_it[0].uz   <= qaar_pkg::clamp_axis(i_axis_z);
            for (int k = 0; k < N; k++) begin
                r_it[k+1] <= r_it[k];
            end
        end
    end

    // stage a: quaternion
    logic signed [CW-1:0] r_qa, r_qb, r_qc, r_qd;
    qaar_pkg::t_vec r_v_a, r_v_b, r_v_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qa  <= w_cos;
            r_qb  <= CW'(qaar_pkg::rnd(72'(r_it[N].ux * w_sin), 14));
            r_qc  <= CW'(qaar_pkg::rnd(72'(r_it[N].uy * w_sin), 14));
            r_qd  <= CW'(qaar_pkg::rnd(72'(r_it[N].uz * w_sin), 14));
            r_v_a <= r_it[N].v;
        end
    end

    // stage b: pairwise products in q.30
    logic signed [CW-1:0] r_aa, r_bb, r_cc, r_dd, r_ab, r_ac, r_ad, r_bc, r_bd, r_cd;

    function automatic logic signed [CW-1:0] mq(input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y);
        return CW'(qaar_pkg::rnd(72'(x * y), 30));
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_aa  <= mq(r_qa, r_qa);
            r_bb  <= mq(r_qb, r_qb);
            r_cc  <= mq(r_qc, r_qc);
            r_dd  <= mq(r_qd, r_qd);
            r_ab  <= mq(r_qa, r_qb);
            r_ac  <= mq(r_qa, r_qc);
            r_ad  <= mq(r_qa, r_qd);
            r_bc  <= mq(r_qb, r_qc);
            r_bd  <= mq(r_qb, r_qd);
            r_cd  <= mq(r_qc, r_qd);
            r_v_b <= r_v_a;
        end
    end

    // stage c: matrix entries rounded to q.28
    logic signed [EW-1:0] w_m [0:8];
    logic signed [CW-1:0] r_m [0:8];

    always_comb begin
        w_m[0] = EW'(r_aa) + EW'(r_bb) - EW'(r_cc) - EW'(r_dd);
        w_m[1] = (EW'(r_bc) - EW'(r_ad)) <<< 1;
        w_m[2] = (EW'(r_bd) + EW'(r_ac)) <<< 1;
        w_m[3] = (EW'(r_bc) + EW'(r_ad)) <<< 1;
        w_m[4] = EW'(r_aa) - EW'(r_bb) + EW'(r_cc) - EW'(r_dd);
        w_m[5] = (EW'(r_cd) - EW'(r_ab)) <<< 1;
        w_m[6] = (EW'(r_bd) - EW'(r_ac)) <<< 1;
        w_m[7] = (EW'(r_cd) + EW'(r_ab)) <<< 1;
        w_m[8] = EW'(r_aa) - EW'(r_bb) - EW'(r_cc) + EW'(r_dd);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= CW'(qaar_pkg::rnd(72'(w_m[k]), 2));
            end
            r_v_c <= r_v_b;
        end
    end

    // stage d: entry times vector component, q.44 to q.16
    logic signed [TW-1:0] r_t [0:8];
    logic signed [31:0]   w_vs [0:2];

    assign w_vs[0] = r_v_c.vx;
    assign w_vs[1] = r_v_c.vy;
    assign w_vs[2] = r_v_c.vz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_t[k] <= TW'(qaar_pkg::rnd(72'(r_m[k] * w_vs[k % 3]), 28));
            end
        end
    end

    // stage e: row sums with saturation
    logic signed [SW-1:0] w_s [0:2];
    logic signed [31:0]   r_rot [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_s[r] = SW'(r_t[3*r]) + SW'(r_t[3*r+1]) + SW'(r_t[3*r+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                if (w_s[r] > SW'(64'sd2147483647)) begin
                    r_rot[r] <= 32'sh7fffffff;
                end else if (w_s[r] < -SW'(64'sd2147483648)) begin
                    r_rot[r] <= 32'sh80000000;
                end else begin
                    r_rot[r] <= w_s[r][31:0];
                end
            end
        end
    end

    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];

    // the pipeline only halts with a full output register
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_vld)
        else $error("stall raised with empty output register");

    a_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_vld[0] == $past(i_valid)))
        else $error("accepted request lost at pipeline entry");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vld_a) && $stable(r_vld_d) && $stable(r_vld[N])))
        else $error("valid bits moved during stall");

endmodule
`default_nettype wire

/* sv/qaar_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qaar_cordic
// pipelined rotation-mode cordic giving cos and sin of the half angle
// ----------------------------------------------------------------------------
module qaar_cordic (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [15:0]                    i_angle,
    output logic signed [qaar_pkg::CW-1:0]      o_cos,
    output logic signed [qaar_pkg::CW-1:0]      o_sin
);

    localparam int N = qaar_pkg::NSTG;

    logic signed [qaar_pkg::CW-1:0] r_x  [0:N];
    logic signed [qaar_pkg::CW-1:0] r_y  [0:N];
    logic signed [qaar_pkg::ZW-1:0] r_z  [0:N];
    logic                           r_up [0:N];

    // upper half: start from the angle less a quarter turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= qaar_pkg::CORDIC_GAIN;
            r_y[0]  <= '0;
            r_z[0]  <= qaar_pkg::ZW'({i_angle[14:0], 15'b0});
            r_up[0] <= i_angle[15];
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [qaar_pkg::CW-1:0] w_dx, w_dy;
        assign w_dx = r_y[g] >>> g;
        assign w_dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_up[g+1] <= r_up[g];
                if (!r_z[g][qaar_pkg::ZW-1]) begin
                    r_x[g+1] <= r_x[g] - w_dx;
                    r_y[g+1] <= r_y[g] + w_dy;
                    r_z[g+1] <= r_z[g] - qaar_pkg::atan_bam(g);
                end else begin
                    r_x[g+1] <= r_x[g] + w_dx;
                    r_y[g+1] <= r_y[g] - w_dy;
                    r_z[g+1] <= r_z[g] + qaar_pkg::atan_bam(g);
                end
            end
        end
    end

    assign o_cos = r_up[N] ? -r_y[N] : r_x[N];
    assign o_sin = r_up[N] ? r_x[N] : r_y[N];

endmodule
`default_nettype wire
